>>> design/fmb_pkg.sv
// Shared types, constants and the auto duty table for the fan mode controller.
`default_nettype none

package fmb_pkg;

  typedef enum logic [1:0] {
    REG_PERIOD_TOP        = 2'd0,
    REG_DEBOUNCE_MS       = 2'd1,
    REG_LONG_HOLD_MS      = 2'd2,
    REG_BUTTON_ACTIVE_LOW = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_POLL = 1'b0,
    CMD_TEMP = 1'b1
  } cmd_t;

  localparam logic [15:0] PERIOD_TOP_RST        = 16'd999;
  localparam logic [7:0]  DEBOUNCE_MS_RST       = 8'd20;
  localparam logic [15:0] LONG_HOLD_MS_RST      = 16'd1500;
  localparam logic        BUTTON_ACTIVE_LOW_RST = 1'b1;

  localparam logic signed [7:0] TEMP_LOW  = 8'sd32;
  localparam logic signed [7:0] TEMP_HIGH = 8'sd38;
  localparam logic [6:0] DUTY_OFF  = 7'd0;
  localparam logic [6:0] DUTY_FULL = 7'd100;

  localparam int PROD_W      = 23;
  localparam int CMP_W       = 17;
  localparam int DIV100_SH   = 30;
  localparam logic [23:0] DIV100_MUL = 24'd10737419;

  typedef struct packed {
    logic [15:0] period_top;
    logic [7:0]  debounce_ms;
    logic [15:0] long_hold_ms;
    logic        button_active_low;
  } cfg_t;

  typedef struct packed {
    logic [PROD_W-1:0] product;
    logic [6:0]        duty;
    logic              mode_manual;
    logic              manual_is_on;
    logic              button_stable;
  } stage_t;

  function automatic logic [6:0] auto_duty(input logic signed [7:0] t);
    logic [6:0] d;
    if (t <= TEMP_LOW) begin
      d = DUTY_OFF;
    end else if (t >= TEMP_HIGH) begin
      d = DUTY_FULL;
    end else begin
      case (t[2:0])
        3'd1:    d = 7'd58;
        3'd2:    d = 7'd66;
        3'd3:    d = 7'd75;
        3'd4:    d = 7'd83;
        default: d = 7'd91;
      endcase
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> design/fmb_ctrl.sv
// Button debounce, press tracking, mode and duty state, and the compare product stage.
`default_nettype none

module fmb_ctrl
  import fmb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              accept,
  input  wire logic              cmd,
  input  wire logic [31:0]       now_ms,
  input  wire logic              button_pin,
  input  wire logic signed [7:0] temp_c,
  input  wire logic              temp_valid,
  input  wire logic              take,
  output logic                   stage_valid,
  output stage_t                 stage
);

  logic        stable_level, stable_level_next;
  logic [31:0] edge_time, edge_time_next;
  logic        press_active, press_active_next;
  logic [31:0] press_start_time, press_start_time_next;
  logic        long_consumed, long_consumed_next;
  logic        mode, mode_next;
  logic        manual_on, manual_on_next;
  logic [6:0]  duty, duty_next;

  logic        raw;
  logic [31:0] edge_diff;
  logic [31:0] hold_diff;
  logic [16:0] period_plus;
  logic [23:0] product_full;

  always_comb begin
    raw                   = cfg.button_active_low ? ~button_pin : button_pin;
    stable_level_next     = stable_level;
    edge_time_next        = edge_time;
    press_active_next     = press_active;
    press_start_time_next = press_start_time;
    long_consumed_next    = long_consumed;
    mode_next             = mode;
    manual_on_next        = manual_on;
    duty_next             = duty;
    edge_diff             = now_ms - edge_time;
    hold_diff             = 32'd0;

    if (cmd == CMD_POLL) begin
      if (raw != stable_level) begin
        if (edge_diff >= {24'd0, cfg.debounce_ms}) begin
          stable_level_next = raw;
          edge_time_next    = now_ms;
        end
      end else begin
        edge_time_next = now_ms;
      end

      if (!stable_level_next) begin
        long_consumed_next = 1'b0;
      end

      if (stable_level_next && !press_active && !long_consumed_next) begin
        press_active_next     = 1'b1;
        press_start_time_next = now_ms;
      end

      hold_diff = now_ms - press_start_time_next;
      if (press_active_next) begin
        if (stable_level_next && hold_diff >= {16'd0, cfg.long_hold_ms}) begin
          mode_next          = 1'b0;
          press_active_next  = 1'b0;
          long_consumed_next = 1'b1;
        end else if (!stable_level_next) begin
          mode_next         = 1'b1;
          manual_on_next    = ~manual_on;
          press_active_next = 1'b0;
        end
      end
    end else begin
      if (mode) begin
        duty_next = manual_on ? DUTY_FULL : DUTY_OFF;
      end else begin
        duty_next = temp_valid ? auto_duty(temp_c) : DUTY_OFF;
      end
    end

    period_plus  = {1'b0, cfg.period_top} + 17'd1;
    product_full = {7'd0, period_plus} * {17'd0, duty_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level     <= 1'b0;
      edge_time        <= 32'd0;
      press_active     <= 1'b0;
      press_start_time <= 32'd0;
      long_consumed    <= 1'b0;
      mode             <= 1'b0;
      manual_on        <= 1'b0;
      duty             <= DUTY_OFF;
    end else if (accept) begin
      stable_level     <= stable_level_next;
      edge_time        <= edge_time_next;
      press_active     <= press_active_next;
      press_start_time <= press_start_time_next;
      long_consumed    <= long_consumed_next;
      mode             <= mode_next;
      manual_on        <= manual_on_next;
      duty             <= duty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (take) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.product       <= product_full[PROD_W-1:0];
      stage.duty          <= duty_next;
      stage.mode_manual   <= mode_next;
      stage.manual_is_on  <= manual_on_next;
      stage.button_stable <= stable_level_next;
    end
  end

endmodule

`default_nettype wire

>>> design/fmb_div100.sv
// Divide-by-100 of the compare product and the result register.
`default_nettype none

module fmb_div100
  import fmb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             stage_valid,
  input  wire stage_t           stage,
  output logic                  take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [6:0]            duty_pct,
  output logic [CMP_W-1:0]      compare_value,
  output logic                  mode_manual,
  output logic                  manual_is_on,
  output logic                  button_stable
);

  logic [PROD_W+23:0] scaled;
  logic               load;

  always_comb begin
    scaled = {24'd0, stage.product} * {{PROD_W{1'b0}}, DIV100_MUL};
    load   = !out_valid || out_ready;
    take   = stage_valid && load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      duty_pct      <= stage.duty;
      compare_value <= scaled[DIV100_SH+CMP_W-1:DIV100_SH];
      mode_manual   <= stage.mode_manual;
      manual_is_on  <= stage.manual_is_on;
      button_stable <= stage.button_stable;
    end
  end

endmodule

`default_nettype wire

>>> design/fan_mode_button_and_temp_duty.sv
// Top level of the fan controller: configuration registers, state stage and result stage.
//
//   channel | handshake            | payload
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in_valid/in_ready    | cmd, now_ms, button_pin, temp_c, temp_valid
//   out     | out_valid/out_ready  | duty_pct, compare_value, mode_manual,
//           |                      | manual_is_on, button_stable
//
// One item per cycle unless the output stalls; items pass the stage and output registers.
// The first stage updates button and duty state and forms (period_top+1)*duty; the
// second divides by 100 with a reciprocal multiply into the output register.
// A stalled output holds both stages; in_ready drops only when both are full.
// Synchronous reset restores config, button and duty state and valid flags, not payloads.
`default_nettype none

module fan_mode_button_and_temp_duty
  import fmb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              cmd,
  input  wire logic [31:0]       now_ms,
  input  wire logic              button_pin,
  input  wire logic signed [7:0] temp_c,
  input  wire logic              temp_valid,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [6:0]             duty_pct,
  output logic [CMP_W-1:0]       compare_value,
  output logic                   mode_manual,
  output logic                   manual_is_on,
  output logic                   button_stable
);

  cfg_t   cfg;
  stage_t stage;
  logic   stage_valid;
  logic   take;
  logic   accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !stage_valid || take;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_top        <= PERIOD_TOP_RST;
      cfg.debounce_ms       <= DEBOUNCE_MS_RST;
      cfg.long_hold_ms      <= LONG_HOLD_MS_RST;
      cfg.button_active_low <= BUTTON_ACTIVE_LOW_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PERIOD_TOP:        cfg.period_top        <= cfg_data;
        REG_DEBOUNCE_MS:       cfg.debounce_ms       <= cfg_data[7:0];
        REG_LONG_HOLD_MS:      cfg.long_hold_ms      <= cfg_data;
        REG_BUTTON_ACTIVE_LOW: cfg.button_active_low <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fmb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .cmd         (cmd),
    .now_ms      (now_ms),
    .button_pin  (button_pin),
    .temp_c      (temp_c),
    .temp_valid  (temp_valid),
    .take        (take),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  fmb_div100 u_div100 (
    .clk           (clk),
    .rst           (rst),
    .stage_valid   (stage_valid),
    .stage         (stage),
    .take          (take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .duty_pct      (duty_pct),
    .compare_value (compare_value),
    .mode_manual   (mode_manual),
    .manual_is_on  (manual_is_on),
    .button_stable (button_stable)
  );

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty_pct <= DUTY_FULL)
    else $error("duty above 100 percent");

  a_cmp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> compare_value <= 17'd65536)
    else $error("compare value out of range");

  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && duty_pct == DUTY_OFF |-> compare_value == 17'd0)
    else $error("nonzero compare value at zero duty");

  a_accept_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> stage_valid)
    else $error("accepted item missing from first stage");

endmodule

`default_nettype wire

>>> tb/sv/fan_status_checker.sv
// Checker for the fan controller: tracks config and items, predicts each result and compares.
`timescale 1ns / 100ps

module fan_status_checker
  import fmb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              cmd,
  input  logic [31:0]       now_ms,
  input  logic              button_pin,
  input  logic signed [7:0] temp_c,
  input  logic              temp_valid,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [6:0]        duty_pct,
  input  logic [CMP_W-1:0]  compare_value,
  input  logic              mode_manual,
  input  logic              manual_is_on,
  input  logic              button_stable,
  output int                pending,
  output int                fail_count
);

  typedef struct packed {
    logic [6:0]       duty;
    logic [CMP_W-1:0] cmp;
    logic             manual;
    logic             man_on;
    logic             pressed;
  } fan_status_t;

  logic [15:0] period_r;
  logic [7:0]  debounce_r;
  logic [15:0] long_r;
  logic        active_low_r;

  logic        stable_lvl;
  logic [31:0] edge_ms;
  logic        press_on;
  logic [31:0] press_t0;
  logic        long_done;
  logic        manual_mode;
  logic        manual_run;
  logic [6:0]  duty_now;

  fan_status_t status_q[$];

  function automatic logic [6:0] auto_target(input logic signed [7:0] t);
    int span;
    if (t <= TEMP_LOW) return DUTY_OFF;
    if (t >= TEMP_HIGH) return DUTY_FULL;
    span = t;
    span = span - 32;
    return 7'(50 + (span * 50) / 6);
  endfunction

  task automatic advance_button(input logic [31:0] now, input logic pin);
    logic        raw;
    logic [31:0] held;
    raw  = active_low_r ? ~pin : pin;
    held = now - edge_ms;
    if (raw != stable_lvl) begin
      if (held >= {24'd0, debounce_r}) begin
        stable_lvl = raw;
        edge_ms    = now;
      end
    end else begin
      edge_ms = now;
    end
    if (!stable_lvl) long_done = 1'b0;
    if (stable_lvl && !press_on && !long_done) begin
      press_on = 1'b1;
      press_t0 = now;
    end
    if (press_on) begin
      held = now - press_t0;
      if (stable_lvl && held >= {16'd0, long_r}) begin
        manual_mode = 1'b0;
        press_on    = 1'b0;
        long_done   = 1'b1;
      end else if (!stable_lvl) begin
        manual_mode = 1'b1;
        manual_run  = ~manual_run;
        press_on    = 1'b0;
      end
    end
  endtask

  task automatic set_duty(input logic signed [7:0] t, input logic t_ok);
    if (manual_mode) duty_now = manual_run ? DUTY_FULL : DUTY_OFF;
    else duty_now = t_ok ? auto_target(t) : DUTY_OFF;
  endtask

  function automatic fan_status_t current_status();
    fan_status_t s;
    int          prod;
    prod      = (int'(period_r) + 1) * int'(duty_now);
    s.duty    = duty_now;
    s.cmp     = CMP_W'(prod / 100);
    s.manual  = manual_mode;
    s.man_on  = manual_run;
    s.pressed = stable_lvl;
    return s;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    fan_status_t want_s;
    if (rst) begin
      period_r     = PERIOD_TOP_RST;
      debounce_r   = DEBOUNCE_MS_RST;
      long_r       = LONG_HOLD_MS_RST;
      active_low_r = BUTTON_ACTIVE_LOW_RST;
      stable_lvl   = 1'b0;
      edge_ms      = '0;
      press_on     = 1'b0;
      press_t0     = '0;
      long_done    = 1'b0;
      manual_mode  = 1'b0;
      manual_run   = 1'b0;
      duty_now     = DUTY_OFF;
      status_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_PERIOD_TOP:        period_r     = cfg_data;
          REG_DEBOUNCE_MS:       debounce_r   = cfg_data[7:0];
          REG_LONG_HOLD_MS:      long_r       = cfg_data;
          REG_BUTTON_ACTIVE_LOW: active_low_r = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (cmd_t'(cmd) == CMD_POLL) advance_button(now_ms, button_pin);
        else set_duty(temp_c, temp_valid);
        status_q.push_back(current_status());
      end
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, actual duty %0d cmp %0d",
                   $time, duty_pct, compare_value);
        end else begin
          want_s = status_q.pop_front();
          check_field("duty_pct", want_s.duty, duty_pct);
          check_field("compare_value", want_s.cmp, compare_value);
          check_field("mode_manual", want_s.manual, mode_manual);
          check_field("manual_is_on", want_s.man_on, manual_is_on);
          check_field("button_stable", want_s.pressed, button_stable);
        end
      end
      pending <= status_q.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the fan controller testbench: clock, reset, config phases, item stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import fmb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 180;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [15:0]       cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              cmd;
  logic [31:0]       now_ms;
  logic              button_pin;
  logic signed [7:0] temp_c;
  logic              temp_valid;
  logic              out_valid;
  logic              out_ready;
  logic [6:0]        duty_pct;
  logic [CMP_W-1:0]  compare_value;
  logic              mode_manual;
  logic              manual_is_on;
  logic              button_stable;

  int pending;
  int fail_count;

  bit          throttle  = 1'b1;
  bit          hold_out  = 1'b0;
  int unsigned deb_cfg   = 20;
  int unsigned long_cfg  = 1500;
  logic        al_cfg    = 1'b1;
  logic [31:0] t_ms      = '0;
  logic        want_press = 1'b0;

  fan_mode_button_and_temp_duty DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .now_ms(now_ms),
    .button_pin(button_pin), .temp_c(temp_c), .temp_valid(temp_valid),
    .out_valid(out_valid), .out_ready(out_ready), .duty_pct(duty_pct),
    .compare_value(compare_value), .mode_manual(mode_manual),
    .manual_is_on(manual_is_on), .button_stable(button_stable)
  );

  fan_status_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .now_ms(now_ms),
    .button_pin(button_pin), .temp_c(temp_c), .temp_valid(temp_valid),
    .out_valid(out_valid), .out_ready(out_ready), .duty_pct(duty_pct),
    .compare_value(compare_value), .mode_manual(mode_manual),
    .manual_is_on(manual_is_on), .button_stable(button_stable),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    bit held_once;
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_out && !held_once) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_once = 1'b1;
      end else if (throttle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic c, input logic [31:0] t, input logic pin,
                           input logic signed [7:0] tc, input logic tv);
    if (throttle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    now_ms     <= t;
    button_pin <= pin;
    temp_c     <= tc;
    temp_valid <= tv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] per, input logic [7:0] db,
                              input logic [15:0] lp, input logic al);
    write_reg(REG_PERIOD_TOP, per);
    write_reg(REG_DEBOUNCE_MS, {8'd0, db});
    write_reg(REG_LONG_HOLD_MS, lp);
    write_reg(REG_BUTTON_ACTIVE_LOW, {15'd0, al});
    cfg_valid <= 1'b0;
    deb_cfg  = db;
    long_cfg = lp;
    al_cfg   = al;
  endtask

  // drop valid, then wait out every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(CMD_TEMP, $urandom, 1'b0, -8'sd128, 1'b1);
    send_item(CMD_TEMP, $urandom, 1'b1, 8'sd127, 1'b1);
    send_item(CMD_TEMP, $urandom, 1'b0, 8'sd32, 1'b1);
    send_item(CMD_TEMP, $urandom, 1'b1, 8'sd33, 1'b1);
    send_item(CMD_TEMP, $urandom, 1'b0, 8'sd34, 1'b1);
    send_item(CMD_TEMP, $urandom, 1'b1, 8'sd35, 1'b1);
    send_item(CMD_TEMP, $urandom, 1'b0, 8'sd36, 1'b1);
    send_item(CMD_TEMP, $urandom, 1'b1, 8'sd37, 1'b1);
    send_item(CMD_TEMP, $urandom, 1'b0, 8'sd38, 1'b1);
    send_item(CMD_TEMP, $urandom, 1'b1, 8'sd35, 1'b0);
    // short press across the timestamp wrap
    send_item(CMD_POLL, 32'hFFFF_FFF0, 1'b0, -8'sd1, 1'b0);
    send_item(CMD_POLL, 32'h0000_0005, 1'b1, 8'sd0, 1'b1);
    send_item(CMD_TEMP, 32'hFFFF_FFFF, 1'b0, 8'sd20, 1'b1);
    // bounce, then steady level
    send_item(CMD_POLL, 32'd10, 1'b0, 8'sd0, 1'b0);
    send_item(CMD_POLL, 32'd15, 1'b1, 8'sd0, 1'b0);
    // long press, held on, then its release
    send_item(CMD_POLL, 32'd40, 1'b0, 8'sd0, 1'b0);
    send_item(CMD_POLL, 32'd1540, 1'b0, 8'sd0, 1'b0);
    send_item(CMD_POLL, 32'd1600, 1'b0, 8'sd0, 1'b0);
    send_item(CMD_POLL, 32'd1700, 1'b1, 8'sd0, 1'b0);
    send_item(CMD_TEMP, 32'd1750, 1'b1, 8'sd36, 1'b1);
    send_item(CMD_POLL, 32'd1800, 1'b0, 8'sd0, 1'b0);
    send_item(CMD_POLL, 32'd1900, 1'b1, 8'sd0, 1'b0);
    send_item(CMD_TEMP, 32'd1950, 1'b1, 8'sd36, 1'b1);
    send_item(CMD_TEMP, 32'd2000, 1'b0, -8'sd1, 1'b0);
  endtask

  function automatic logic [31:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, deb_cfg / 2 + 1);
    if (r < 80) return $urandom_range(deb_cfg, deb_cfg + 30);
    if (r < 92) return $urandom_range(0, long_cfg / 4 + 2);
    return $urandom_range(long_cfg / 2, long_cfg + long_cfg / 2 + 2);
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned       r;
    logic              pin;
    logic signed [7:0] tc;
    logic              tv;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        if ($urandom_range(0, 9) < 7) tc = 8'($urandom_range(26, 44));
        else tc = 8'($urandom);
        tv = ($urandom_range(0, 9) != 0);
        send_item(CMD_TEMP, $urandom, 1'($urandom), tc, tv);
      end else begin
        if (r < 32) t_ms = $urandom;
        else t_ms = t_ms + pick_step();
        if ($urandom_range(0, 9) == 0) want_press = ~want_press;
        pin = want_press ^ al_cfg;
        if ($urandom_range(0, 9) == 0) pin = ~pin;
        send_item(CMD_POLL, t_ms, pin, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned phase;
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_PERIOD_TOP;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    cmd        <= CMD_POLL;
    now_ms     <= '0;
    button_pin <= 1'b1;
    temp_c     <= '0;
    temp_valid <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    settle();
    for (phase = 1; phase <= PHASES; phase++) begin
      throttle = (phase != PHASES);
      case (phase)
        1: program_regs(16'd0, 8'd0, 16'd0, 1'b0);
        2: program_regs(16'hFFFF, 8'd255, 16'hFFFF, 1'b1);
        3: program_regs(16'hFFFF, 8'd0, 16'd1, 1'b0);
        default: program_regs(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 40)),
                              16'($urandom_range(1, 3000)), 1'($urandom));
      endcase
      if (phase % 2 == 1) t_ms = 32'hFFFF_FF00 - $urandom_range(0, 4000);
      else t_ms = $urandom;
      if (phase == 2) hold_out = 1'b1;
      run_random(PHASE_ITEMS);
      settle();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
